@@ design/lqq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at quaternion package
// Shared word types, fixed-point constants and the output rounding function.
// ----------------------------------------------------------------------------
package lqq_pkg;

	localparam int QUAT_FRAC_BITS = 14;
	localparam int UNIT_BITS      = 30;
	localparam int QSHIFT         = UNIT_BITS - QUAT_FRAC_BITS;

	localparam int DIFF_W  = 33;
	localparam int VEC_W   = 34;
	localparam int CROSS_W = 63;
	localparam int COMP_W  = 32;
	localparam int TERM_W  = 35;
	localparam int PAIR_W  = 33;
	localparam int ROOT_W  = 32;
	localparam int QV_W    = 34;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;
	localparam logic [1:0] AX_W = 2'd3;

	localparam logic signed [TERM_W-1:0] ONE_TERM = TERM_W'(64'd1 << UNIT_BITS);
	localparam logic signed [QV_W-1:0]   ONE_QV   = QV_W'(64'd1 << UNIT_BITS);
	localparam logic [QV_W:0] ROUND_HALF = (QV_W + 1)'((64'd1 << QSHIFT) >> 1);
	localparam logic [QV_W:0] SAT_LIM    = (QV_W + 1)'(64'd1 << QUAT_FRAC_BITS);

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
	} lqq_req_t;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic               degenerate;
	} lqq_rsp_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dz;
		logic                     degen;
	} lqq_work_t;

	function automatic logic signed [TERM_W-1:0] lqq_tx(input logic [COMP_W-1:0] a);
		return {{(TERM_W - COMP_W){a[COMP_W-1]}}, a};
	endfunction

	function automatic logic signed [PAIR_W-1:0] lqq_px(input logic [COMP_W-1:0] a);
		return {{(PAIR_W - COMP_W){a[COMP_W-1]}}, a};
	endfunction

	// Rounds a Q30 value to nearest, ties away from zero, then saturates.
	function automatic logic signed [15:0] lqq_round_sat(input logic signed [QV_W-1:0] v);
		logic [QV_W:0] mag;
		logic [QV_W:0] r;
		logic signed [15:0] res;
		mag = v[QV_W-1] ? (QV_W + 1)'(-v) : (QV_W + 1)'(v);
		r = (mag + ROUND_HALF) >> QSHIFT;
		if (r > SAT_LIM) begin
			r = SAT_LIM;
		end
		if (!v[QV_W-1]) begin
			res = (r > (QV_W + 1)'(32767)) ? 16'sh7fff : 16'(r);
		end else begin
			res = (r > (QV_W + 1)'(32768)) ? 16'sh8000 : 16'(-r);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

@@ design/lookat_to_quaternion_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at to quaternion core
// Turns an eye and a target position into the look-at orientation quaternion.
// ----------------------------------------------------------------------------
// The core accepts one request word per clock while req_ready is high and
// returns one response word per request, in order. Bit-per-stage square root
// and divider pipelines are used in the three vector normalizations and in
// the quaternion extraction. A four-entry queue with a registered output
// sits between the front end and the arithmetic pipeline, and the arithmetic
// pipeline holds while a response waits to be taken. Directions that are
// zero or straight up or down return the identity with the degenerate bit
// set.
module lookat_to_quaternion_core import lqq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  lqq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output lqq_rsp_t rsp
);

	logic      push_valid;
	logic      push_ready;
	lqq_work_t push_word;
	logic      pop_valid;
	logic      pop_ready;
	lqq_work_t pop_word;

	lqq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word (push_word)
	);

	lqq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word (push_word),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_word  (pop_word)
	);

	lqq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.work     (pop_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

@@ design/lqq_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage, with a side word alongside.
// ----------------------------------------------------------------------------
module lqq_isqrt #(
	parameter int W  = 31,
	parameter int SW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [2*W-1:0] in_n,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [W-1:0]   out_root,
	output logic [SW-1:0]  out_side
);

	logic           vld_s  [W+1];
	logic [2*W-1:0] rem_s  [W+1];
	logic [W-1:0]   root_s [W+1];
	logic [SW-1:0]  side_s [W+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = in_n;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < W; g++) begin : g_step
		localparam int B = W - 1 - g;
		logic [2*W-1:0] trial;

		assign trial = ((2*W)'(root_s[g]) << (B + 1)) | ((2*W)'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				if (rem_s[g] >= trial) begin
					rem_s[g+1]  <= rem_s[g] - trial;
					root_s[g+1] <= root_s[g] | (W'(1) << B);
				end else begin
					rem_s[g+1]  <= rem_s[g];
					root_s[g+1] <= root_s[g];
				end
			end
		end
	end

	assign out_valid = vld_s[W];
	assign out_root  = root_s[W];
	assign out_side  = side_s[W];

endmodule
`default_nettype wire

@@ design/lqq_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with a side word alongside.
// ----------------------------------------------------------------------------
module lqq_div #(
	parameter int NW = 60,
	parameter int DW = 31,
	parameter int QW = 31,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [SW-1:0] out_side
);

	localparam int CW = DW + QW;

	logic          vld_s  [QW+1];
	logic [CW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = CW'(in_num);
	assign den_s[0]  = in_den;
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < QW; g++) begin : g_step
		localparam int J = QW - 1 - g;
		logic [CW-1:0] trial;

		assign trial = CW'(den_s[g]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g+1]  <= den_s[g];
				side_s[g+1] <= side_s[g];
				if (rem_s[g] >= trial) begin
					rem_s[g+1] <= rem_s[g] - trial;
					quo_s[g+1] <= quo_s[g] | (QW'(1) << J);
				end else begin
					rem_s[g+1] <= rem_s[g];
					quo_s[g+1] <= quo_s[g];
				end
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_side  = side_s[QW];

endmodule
`default_nettype wire

@@ design/lqq_unit3.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a 3-vector to a Q2.30 unit vector through a square root and three
// dividers; flags an all-zero vector.
// ----------------------------------------------------------------------------
module lqq_unit3 import lqq_pkg::*; #(
	parameter int IW = 34,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [2:0][IW-1:0]     in_vec,
	input  logic [SW-1:0]          in_side,
	output logic                   out_valid,
	output logic [2:0][COMP_W-1:0] out_vec,
	output logic                   out_zero,
	output logic [SW-1:0]          out_side
);

	localparam int PW   = $clog2(IW);
	localparam int SQ_W = 2 * UNIT_BITS;
	localparam int SS_W = 2 * (UNIT_BITS + 1);
	localparam int LW   = UNIT_BITS + 1;
	localparam int ISW  = 3 * UNIT_BITS + 3 + 1 + SW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [2:0][IW-1:0] mag_c, mag_s1, mag_s2;
	logic [2:0] sgn_s1, sgn_s2, sgn_s3, sgn_s4, sgn_s5;
	logic [IW-1:0] any_s1;
	logic [SW-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [PW-1:0] pos_c, pos_s2;
	logic zero_s2, zero_s3, zero_s4, zero_s5;
	logic [2:0][UNIT_BITS-1:0] mn_c, mn_s3, mn_s4, mn_s5;
	logic [2:0][SQ_W-1:0] sq_s4;
	logic [SS_W-1:0] ss_s5;

	logic           sq_valid;
	logic [LW-1:0]  len;
	logic [ISW-1:0] sq_side;
	logic [2:0][UNIT_BITS-1:0] mn_r;
	logic [2:0] sgn_r;
	logic zero_r;
	logic [SW-1:0] side_r;

	logic [2:0] d_valid;
	logic [2:0][LW-1:0] quo;
	logic [SW+1:0] d0_side;
	logic d_sgn0, d_sgn1, d_sgn2, d_zero;
	logic [SW-1:0] d_side;

	logic [2:0][COMP_W-1:0] vec_s6;
	logic zero_s6;
	logic [SW-1:0] side_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][IW-1] ? (IW'(0) - in_vec[i]) : in_vec[i];
		end
	end

	always_comb begin
		pos_c = '0;
		for (int i = 0; i < IW; i++) begin
			if (any_s1[i]) begin
				pos_c = PW'(i);
			end
		end
	end

	always_comb begin
		logic [IW-1:0] sh;
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= PW'(UNIT_BITS - 1)) begin
				sh = mag_s2[i] >> (pos_s2 - PW'(UNIT_BITS - 1));
			end else begin
				sh = mag_s2[i] << (PW'(UNIT_BITS - 1) - pos_s2);
			end
			mn_c[i] = sh[UNIT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= &d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			any_s1  <= mag_c[0] | mag_c[1] | mag_c[2];
			sgn_s1  <= {in_vec[2][IW-1], in_vec[1][IW-1], in_vec[0][IW-1]};
			side_s1 <= in_side;

			mag_s2  <= mag_s1;
			pos_s2  <= pos_c;
			zero_s2 <= (any_s1 == '0);
			sgn_s2  <= sgn_s1;
			side_s2 <= side_s1;

			mn_s3   <= mn_c;
			zero_s3 <= zero_s2;
			sgn_s3  <= sgn_s2;
			side_s3 <= side_s2;

			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= SQ_W'(mn_s3[i]) * SQ_W'(mn_s3[i]);
			end
			mn_s4   <= mn_s3;
			zero_s4 <= zero_s3;
			sgn_s4  <= sgn_s3;
			side_s4 <= side_s3;

			ss_s5   <= SS_W'(sq_s4[0]) + SS_W'(sq_s4[1]) + SS_W'(sq_s4[2]);
			mn_s5   <= mn_s4;
			zero_s5 <= zero_s4;
			sgn_s5  <= sgn_s4;
			side_s5 <= side_s4;
		end
	end

	lqq_isqrt #(.W(LW), .SW(ISW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.in_n     (ss_s5),
		.in_side  ({mn_s5, sgn_s5, zero_s5, side_s5}),
		.out_valid(sq_valid),
		.out_root (len),
		.out_side (sq_side)
	);

	assign {mn_r, sgn_r, zero_r, side_r} = sq_side;

	lqq_div #(.NW(SQ_W), .DW(LW), .QW(LW), .SW(SW + 2)) u_div0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_num   ({mn_r[0], UNIT_BITS'(0)}),
		.in_den   (len),
		.in_side  ({sgn_r[0], zero_r, side_r}),
		.out_valid(d_valid[0]),
		.out_quo  (quo[0]),
		.out_side (d0_side)
	);

	lqq_div #(.NW(SQ_W), .DW(LW), .QW(LW), .SW(1)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_num   ({mn_r[1], UNIT_BITS'(0)}),
		.in_den   (len),
		.in_side  (sgn_r[1]),
		.out_valid(d_valid[1]),
		.out_quo  (quo[1]),
		.out_side (d_sgn1)
	);

	lqq_div #(.NW(SQ_W), .DW(LW), .QW(LW), .SW(1)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_num   ({mn_r[2], UNIT_BITS'(0)}),
		.in_den   (len),
		.in_side  (sgn_r[2]),
		.out_valid(d_valid[2]),
		.out_quo  (quo[2]),
		.out_side (d_sgn2)
	);

	assign {d_sgn0, d_zero, d_side} = d0_side;

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s6[0] <= d_sgn0 ? (COMP_W'(0) - COMP_W'(quo[0])) : COMP_W'(quo[0]);
			vec_s6[1] <= d_sgn1 ? (COMP_W'(0) - COMP_W'(quo[1])) : COMP_W'(quo[1]);
			vec_s6[2] <= d_sgn2 ? (COMP_W'(0) - COMP_W'(quo[2])) : COMP_W'(quo[2]);
			zero_s6   <= d_zero;
			side_s6   <= d_side;
		end
	end

	assign out_valid = v_s6;
	assign out_vec   = vec_s6;
	assign out_zero  = zero_s6;
	assign out_side  = side_s6;

endmodule
`default_nettype wire

@@ design/lqq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at quaternion front end
// Accepts request words, forms the view direction and flags directions that
// are zero or parallel to the world up axis.
// ----------------------------------------------------------------------------
module lqq_front import lqq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  lqq_req_t  req,
	output logic      push_valid,
	input  logic      push_ready,
	output lqq_work_t push_word
);

	logic      v_s1;
	lqq_work_t work_s1;
	lqq_work_t work_c;

	always_comb begin
		work_c.dx    = {req.target_x[31], req.target_x} - {req.eye_x[31], req.eye_x};
		work_c.dy    = {req.target_y[31], req.target_y} - {req.eye_y[31], req.eye_y};
		work_c.dz    = {req.target_z[31], req.target_z} - {req.eye_z[31], req.eye_z};
		work_c.degen = (work_c.dx == '0) && (work_c.dz == '0);
	end

	assign req_ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ready) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			work_s1 <= work_c;
		end
	end

	assign push_valid = v_s1;
	assign push_word  = work_s1;

endmodule
`default_nettype wire

@@ design/lqq_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at quaternion work queue
// Short queue with a registered output that decouples the front end from the
// arithmetic back end.
// ----------------------------------------------------------------------------
module lqq_fifo import lqq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  lqq_work_t push_word,
	output logic      pop_valid,
	input  logic      pop_ready,
	output lqq_work_t pop_word
);

	lqq_work_t          mem [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_ptr_q;
	logic [FIFO_PW-1:0] rd_ptr_q;
	logic [FIFO_PW:0]   count_q;
	logic               out_valid_q;
	lqq_work_t          out_word_q;
	logic               push;
	logic               pop;
	logic               load;

	assign push_ready = (count_q != (FIFO_PW + 1)'(FIFO_DEPTH));
	assign pop_valid  = out_valid_q;
	assign pop_word   = out_word_q;
	assign push       = push_valid && push_ready;
	assign pop        = out_valid_q && pop_ready;
	assign load       = (count_q != '0) && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (load) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !load) begin
				count_q <= count_q + 1'b1;
			end else if (load && !push) begin
				count_q <= count_q - 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
		if (load) begin
			out_word_q <= mem[rd_ptr_q];
		end
	end

endmodule
`default_nettype wire

@@ design/lqq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-at quaternion back end
// Builds the orthonormal basis and converts it to a quaternion by the
// largest-trace-term method, ending in the output register.
// ----------------------------------------------------------------------------
module lqq_back import lqq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  lqq_work_t work,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output lqq_rsp_t  rsp
);

	localparam int YSW = 6 * COMP_W + 1;
	localparam int RSW = 3 * PAIR_W + 3;
	localparam int NUM_W = 2 * UNIT_BITS + 2;
	localparam int DEN_W = ROOT_W + 1;
	localparam int D0SW = ROOT_W + 4;

	logic en;

	logic z_valid, x_valid;
	logic [2:0][COMP_W-1:0] z_vec, x_vec;
	logic z_zero, x_zero, z_side, x_side;

	logic v_c1, v_c2;
	logic signed [63:0] p_c1 [6];
	logic [2:0][COMP_W-1:0] z_c1, x_c1, z_c2, x_c2;
	logic bad_c1, bad_c2;
	logic [2:0][CROSS_W-1:0] yv_c2;

	logic y_valid, y_zero;
	logic [2:0][COMP_W-1:0] y_vec, z_y, x_y;
	logic [YSW-1:0] y_side;
	logic bad_y;

	logic v_e1, v_e2;
	logic signed [TERM_W-1:0] e_e1 [4];
	logic signed [PAIR_W-1:0] r10p01_e1, r02p20_e1, r21m12_e1;
	logic signed [PAIR_W-1:0] r21p12_e1, r02m20_e1, r10m01_e1;
	logic ok_e1, ok_e2;
	logic [1:0] b_c, b_e2;
	logic signed [TERM_W-1:0] eb_c, eb_e2;
	logic [2:0][PAIR_W-1:0] n_c, n_e2;
	logic [2*ROOT_W-1:0] sq_in;

	logic r_valid;
	logic [ROOT_W-1:0] s_r;
	logic [RSW-1:0] r_side;
	logic [2:0][PAIR_W-1:0] n_r;
	logic [1:0] b_r;
	logic ok_r;
	logic [2:0][NUM_W-1:0] num_r;

	logic [2:0] d_valid;
	logic [2:0][ROOT_W-1:0] quo;
	logic [D0SW-1:0] d0_side;
	logic d_sgn0, d_sgn1, d_sgn2, d_ok;
	logic [ROOT_W-1:0] d_s;
	logic [1:0] d_b;

	logic signed [QV_W-1:0] r_c [3];
	logic signed [QV_W-1:0] qb_c;
	logic signed [QV_W-1:0] q_c [4];

	logic     rsp_valid_q;
	lqq_rsp_t rsp_q;

	assign en        = !rsp_valid_q || rsp_ready;
	assign pop_ready = en;

	lqq_unit3 #(.IW(VEC_W), .SW(1)) u_unit_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pop_valid),
		.in_vec   ({{work.dz[DIFF_W-1], work.dz}, {work.dy[DIFF_W-1], work.dy},
		            {work.dx[DIFF_W-1], work.dx}}),
		.in_side  (work.degen),
		.out_valid(z_valid),
		.out_vec  (z_vec),
		.out_zero (z_zero),
		.out_side (z_side)
	);

	lqq_unit3 #(.IW(VEC_W), .SW(1)) u_unit_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pop_valid),
		.in_vec   ({VEC_W'(0) - {work.dx[DIFF_W-1], work.dx}, VEC_W'(0),
		            {work.dz[DIFF_W-1], work.dz}}),
		.in_side  (work.degen),
		.out_valid(x_valid),
		.out_vec  (x_vec),
		.out_zero (x_zero),
		.out_side (x_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1        <= 1'b0;
			v_c2        <= 1'b0;
			v_e1        <= 1'b0;
			v_e2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_c1        <= z_valid && x_valid;
			v_c2        <= v_c1;
			v_e1        <= y_valid;
			v_e2        <= v_e1;
			rsp_valid_q <= &d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_c1[0] <= $signed(z_vec[1]) * $signed(x_vec[2]);
			p_c1[1] <= $signed(z_vec[2]) * $signed(x_vec[1]);
			p_c1[2] <= $signed(z_vec[2]) * $signed(x_vec[0]);
			p_c1[3] <= $signed(z_vec[0]) * $signed(x_vec[2]);
			p_c1[4] <= $signed(z_vec[0]) * $signed(x_vec[1]);
			p_c1[5] <= $signed(z_vec[1]) * $signed(x_vec[0]);
			z_c1    <= z_vec;
			x_c1    <= x_vec;
			bad_c1  <= z_side || x_side || z_zero || x_zero;

			yv_c2[0] <= CROSS_W'(p_c1[0] - p_c1[1]);
			yv_c2[1] <= CROSS_W'(p_c1[2] - p_c1[3]);
			yv_c2[2] <= CROSS_W'(p_c1[4] - p_c1[5]);
			z_c2     <= z_c1;
			x_c2     <= x_c1;
			bad_c2   <= bad_c1;
		end
	end

	lqq_unit3 #(.IW(CROSS_W), .SW(YSW)) u_unit_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_c2),
		.in_vec   (yv_c2),
		.in_side  ({z_c2, x_c2, bad_c2}),
		.out_valid(y_valid),
		.out_vec  (y_vec),
		.out_zero (y_zero),
		.out_side (y_side)
	);

	assign {z_y, x_y, bad_y} = y_side;

	// Matrix columns are x, y, z: m_rc = column c, row r.
	always_ff @(posedge clk) begin
		if (en) begin
			e_e1[0] <= lqq_tx(x_y[0]) - lqq_tx(y_vec[1]) - lqq_tx(z_y[2]) + ONE_TERM;
			e_e1[1] <= lqq_tx(y_vec[1]) - lqq_tx(x_y[0]) - lqq_tx(z_y[2]) + ONE_TERM;
			e_e1[2] <= lqq_tx(z_y[2]) - lqq_tx(x_y[0]) - lqq_tx(y_vec[1]) + ONE_TERM;
			e_e1[3] <= lqq_tx(x_y[0]) + lqq_tx(y_vec[1]) + lqq_tx(z_y[2]) + ONE_TERM;
			r10p01_e1 <= lqq_px(x_y[1]) + lqq_px(y_vec[0]);
			r02p20_e1 <= lqq_px(z_y[0]) + lqq_px(x_y[2]);
			r21m12_e1 <= lqq_px(y_vec[2]) - lqq_px(z_y[1]);
			r21p12_e1 <= lqq_px(y_vec[2]) + lqq_px(z_y[1]);
			r02m20_e1 <= lqq_px(z_y[0]) - lqq_px(x_y[2]);
			r10m01_e1 <= lqq_px(x_y[1]) - lqq_px(y_vec[0]);
			ok_e1     <= !bad_y && !y_zero;
		end
	end

	always_comb begin
		b_c  = AX_X;
		eb_c = e_e1[0];
		for (int i = 1; i < 4; i++) begin
			if (e_e1[i] > eb_c) begin
				b_c  = 2'(i);
				eb_c = e_e1[i];
			end
		end
		unique case (b_c)
			AX_X: n_c = {r21m12_e1, r02p20_e1, r10p01_e1};
			AX_Y: n_c = {r02m20_e1, r21p12_e1, r10p01_e1};
			AX_Z: n_c = {r10m01_e1, r21p12_e1, r02p20_e1};
			default: n_c = {r10m01_e1, r02m20_e1, r21m12_e1};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_e2  <= b_c;
			eb_e2 <= eb_c;
			n_e2  <= n_c;
			ok_e2 <= ok_e1 && !eb_c[TERM_W-1] && (eb_c != '0);
		end
	end

	assign sq_in = ok_e2 ? ((2*ROOT_W)'(eb_e2[32:0]) << UNIT_BITS) : '0;

	lqq_isqrt #(.W(ROOT_W), .SW(RSW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_e2),
		.in_n     (sq_in),
		.in_side  ({n_e2, b_e2, ok_e2}),
		.out_valid(r_valid),
		.out_root (s_r),
		.out_side (r_side)
	);

	assign {n_r, b_r, ok_r} = r_side;

	always_comb begin
		logic [PAIR_W-1:0] mag;
		for (int i = 0; i < 3; i++) begin
			mag      = n_r[i][PAIR_W-1] ? (PAIR_W'(0) - n_r[i]) : n_r[i];
			num_r[i] = {mag[PAIR_W-2:0], UNIT_BITS'(0)};
		end
	end

	lqq_div #(.NW(NUM_W), .DW(DEN_W), .QW(ROOT_W), .SW(D0SW)) u_div0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_valid),
		.in_num   (num_r[0]),
		.in_den   ({s_r, 1'b0}),
		.in_side  ({n_r[0][PAIR_W-1], s_r, b_r, ok_r}),
		.out_valid(d_valid[0]),
		.out_quo  (quo[0]),
		.out_side (d0_side)
	);

	lqq_div #(.NW(NUM_W), .DW(DEN_W), .QW(ROOT_W), .SW(1)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_valid),
		.in_num   (num_r[1]),
		.in_den   ({s_r, 1'b0}),
		.in_side  (n_r[1][PAIR_W-1]),
		.out_valid(d_valid[1]),
		.out_quo  (quo[1]),
		.out_side (d_sgn1)
	);

	lqq_div #(.NW(NUM_W), .DW(DEN_W), .QW(ROOT_W), .SW(1)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (r_valid),
		.in_num   (num_r[2]),
		.in_den   ({s_r, 1'b0}),
		.in_side  (n_r[2][PAIR_W-1]),
		.out_valid(d_valid[2]),
		.out_quo  (quo[2]),
		.out_side (d_sgn2)
	);

	assign {d_sgn0, d_s, d_b, d_ok} = d0_side;

	always_comb begin
		r_c[0] = d_sgn0 ? (QV_W'(0) - QV_W'(quo[0])) : QV_W'(quo[0]);
		r_c[1] = d_sgn1 ? (QV_W'(0) - QV_W'(quo[1])) : QV_W'(quo[1]);
		r_c[2] = d_sgn2 ? (QV_W'(0) - QV_W'(quo[2])) : QV_W'(quo[2]);
		qb_c   = QV_W'(d_s >> 1);
		unique case (d_b)
			AX_X: begin
				q_c[0] = qb_c;   q_c[1] = r_c[0]; q_c[2] = r_c[1]; q_c[3] = r_c[2];
			end
			AX_Y: begin
				q_c[0] = r_c[0]; q_c[1] = qb_c;   q_c[2] = r_c[1]; q_c[3] = r_c[2];
			end
			AX_Z: begin
				q_c[0] = r_c[0]; q_c[1] = r_c[1]; q_c[2] = qb_c;   q_c[3] = r_c[2];
			end
			default: begin
				q_c[0] = r_c[0]; q_c[1] = r_c[1]; q_c[2] = r_c[2]; q_c[3] = qb_c;
			end
		endcase
		if (!d_ok || (d_s == '0)) begin
			q_c[0] = '0;
			q_c[1] = '0;
			q_c[2] = '0;
			q_c[3] = ONE_QV;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.quat_x     <= lqq_round_sat(q_c[0]);
			rsp_q.quat_y     <= lqq_round_sat(q_c[1]);
			rsp_q.quat_z     <= lqq_round_sat(q_c[2]);
			rsp_q.quat_w     <= lqq_round_sat(q_c[3]);
			rsp_q.degenerate <= !d_ok || (d_s == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
